[rtl/spf_pkg.sv]
// Shared types and constants for the sweep-and-prune pair finder.
// Used by the controller, the datapath and the top level; no dependencies.
package spf_pkg;

	localparam int ACTIVE_DEPTH_DEF = 16;
	localparam int COORD_WIDTH_DEF  = 16;
	localparam int MAX_RESULTS      = 16;
	localparam int ID_W             = 16;
	localparam int FIELD_W          = 16;
	localparam int S_TDATA_W        = ID_W + 6 * FIELD_W;
	localparam int S_TUSER_W        = 1;
	localparam int M_TDATA_W        = 2 * ID_W;
	localparam int M_TUSER_W        = 2;

	typedef struct packed {
		logic accept;
		logic scan_rd;
		logic commit;
		logic emit_load;
	} cmd_t;

	typedef struct packed {
		logic list_empty;
		logic scan_last;
		logic out_free;
		logic emit_last;
	} status_t;

endpackage

[rtl/spf_ctrl.sv]
// Sequencing state machine: accept, scan, commit and emit phases.
// Depends on spf_pkg for the command and status structs.
module spf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  spf_pkg::status_t status,
	output spf_pkg::cmd_t    cmd
);
	import spf_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_FLUSH = 5'b00100,
		ST_FIN   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = status.list_empty ? ST_FLUSH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (status.scan_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.commit = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit_load = 1'b1;
					if (status.emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/spf_datapath.sv]
// Active list banks, pruning and overlap compare, pair buffer and output register.
// Depends on spf_pkg; driven by spf_ctrl through cmd_t, reports through status_t.
module spf_datapath #(
	parameter int ACTIVE_DEPTH = spf_pkg::ACTIVE_DEPTH_DEF,
	parameter int COORD_WIDTH  = spf_pkg::COORD_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  spf_pkg::cmd_t                   cmd,
	output spf_pkg::status_t                status,
	input  logic [spf_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [spf_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [spf_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [spf_pkg::M_TUSER_W-1:0]   m_tuser,
	output logic                            m_tlast
);
	import spf_pkg::*;

	localparam int CW     = COORD_WIDTH;
	localparam int BANK_N = ACTIVE_DEPTH + 1;
	localparam int BW     = $clog2(ACTIVE_DEPTH + 1);
	localparam int ENT_W  = ID_W + 5 * CW;
	localparam int PW     = $clog2(MAX_RESULTS);
	localparam int NPW    = $clog2(MAX_RESULTS + 1);

	function automatic logic signed [CW-1:0] cvt(input logic [FIELD_W-1:0] raw);
		logic [31:0] w;
		w = {16'b0, raw};
		return w[CW-1:0];
	endfunction

	logic [ENT_W-1:0] bank0 [BANK_N];
	logic [ENT_W-1:0] bank1 [BANK_N];
	logic [ENT_W-1:0] rd0_s1, rd1_s1, ent_s1;
	logic             rvld_s1;

	logic          sel_q;
	logic [BW-1:0] base_q, count_q, rd_idx_q, kept_q;
	logic [NPW-1:0] npairs_q;
	logic [PW-1:0]  k_q;
	logic           ovf_q;
	logic [ID_W-1:0] pbuf [MAX_RESULTS];

	logic [ID_W-1:0]        id_q;
	logic signed [CW-1:0]   lx_q, ly_q, hy_q, lz_q, hz_q;

	logic                   m_valid_q, m_pv_q, m_ovf_q, m_last_q;
	logic [ID_W-1:0]        m_new_q, m_other_q;

	logic [ID_W-1:0]        in_id;
	logic signed [CW-1:0]   in_lx, in_hx, in_ly, in_hy, in_lz, in_hz;
	logic [ENT_W-1:0]       in_ent;

	logic [ID_W-1:0]        e_id;
	logic signed [CW-1:0]   e_hx, e_ly, e_hy, e_lz, e_hz;
	logic                   keep, hit_y, hit_z, store_pair, ovf_now;
	logic                   wen;
	logic [BW-1:0]          waddr, raddr;
	logic [ENT_W-1:0]       wdata;

	assign in_id  = s_tdata[15:0];
	assign in_lx  = cvt(s_tdata[31:16]);
	assign in_hx  = cvt(s_tdata[47:32]);
	assign in_ly  = cvt(s_tdata[63:48]);
	assign in_hy  = cvt(s_tdata[79:64]);
	assign in_lz  = cvt(s_tdata[95:80]);
	assign in_hz  = cvt(s_tdata[111:96]);
	assign in_ent = {in_id, in_hx, in_ly, in_hy, in_lz, in_hz};

	assign ent_s1 = sel_q ? rd1_s1 : rd0_s1;
	assign e_id   = ent_s1[ENT_W-1 -: ID_W];
	assign e_hx   = ent_s1[5*CW-1 -: CW];
	assign e_ly   = ent_s1[4*CW-1 -: CW];
	assign e_hy   = ent_s1[3*CW-1 -: CW];
	assign e_lz   = ent_s1[2*CW-1 -: CW];
	assign e_hz   = ent_s1[CW-1:0];

	assign keep  = lx_q < e_hx;
	assign hit_y = (ly_q < e_ly) ? (hy_q > e_ly) : (ly_q < e_hy);
	assign hit_z = (lz_q < e_lz) ? (hz_q > e_lz) : (lz_q < e_hz);
	assign store_pair = rvld_s1 && keep && hit_y && hit_z &&
		(npairs_q < NPW'(MAX_RESULTS));

	assign wen   = cmd.accept || (rvld_s1 && keep);
	assign waddr = cmd.accept ? '0 : kept_q + BW'(1);
	assign wdata = cmd.accept ? in_ent : ent_s1;
	assign raddr = base_q + rd_idx_q;

	// Read the current bank, write the other one.
	always_ff @(posedge clk) begin
		if (wen && sel_q) begin
			bank0[waddr] <= wdata;
		end
		if (cmd.scan_rd) begin
			rd0_s1 <= bank0[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (wen && !sel_q) begin
			bank1[waddr] <= wdata;
		end
		if (cmd.scan_rd) begin
			rd1_s1 <= bank1[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (store_pair) begin
			pbuf[npairs_q[PW-1:0]] <= e_id;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			id_q <= in_id;
			lx_q <= in_lx;
			ly_q <= in_ly;
			hy_q <= in_hy;
			lz_q <= in_lz;
			hz_q <= in_hz;
		end
	end

	assign ovf_now = (kept_q == BW'(ACTIVE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1  <= 1'b0;
			sel_q    <= 1'b0;
			base_q   <= '0;
			count_q  <= '0;
			rd_idx_q <= '0;
			kept_q   <= '0;
			npairs_q <= '0;
			k_q      <= '0;
			ovf_q    <= 1'b0;
		end else begin
			rvld_s1 <= cmd.scan_rd;
			if (cmd.accept) begin
				rd_idx_q <= '0;
				kept_q   <= '0;
				npairs_q <= '0;
			end else begin
				if (cmd.scan_rd) begin
					rd_idx_q <= rd_idx_q + BW'(1);
				end
				if (rvld_s1 && keep) begin
					kept_q <= kept_q + BW'(1);
				end
				if (store_pair) begin
					npairs_q <= npairs_q + NPW'(1);
				end
			end
			if (cmd.commit) begin
				sel_q   <= ~sel_q;
				base_q  <= ovf_now ? BW'(1) : '0;
				count_q <= ovf_now ? kept_q : kept_q + BW'(1);
				ovf_q   <= ovf_now;
				k_q     <= '0;
			end else if (cmd.emit_load) begin
				k_q <= k_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			m_pv_q    <= (npairs_q != '0);
			m_new_q   <= id_q;
			m_other_q <= (npairs_q != '0) ? pbuf[k_q] : '0;
			m_ovf_q   <= ovf_q;
			m_last_q  <= status.emit_last;
		end
	end

	assign status.list_empty = s_tuser[0] || (count_q == '0);
	assign status.scan_last  = (rd_idx_q == count_q - BW'(1));
	assign status.out_free   = !m_valid_q || m_tready;
	assign status.emit_last  = (npairs_q == '0) || (NPW'(k_q) == npairs_q - NPW'(1));

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_other_q, m_new_q};
	assign m_tuser  = {m_ovf_q, m_pv_q};
	assign m_tlast  = m_last_q;

endmodule

[rtl/sweep_prune_pair_finder_unit.sv]
// Sweep-and-prune pair finder: prunes the active list and emits overlapping id pairs.
// Flow: no new box is taken until all results (at least 1) of the last box are emitted;
// the active entries are read through the single read port of the active list bank, and
// after flush and commit each result is loaded into the output register as it frees up.
// Reset: arst_n asynchronous, active low; clears the list count and the control state.
// Depends on spf_pkg, spf_ctrl and spf_datapath.
module sweep_prune_pair_finder_unit #(
	parameter int ACTIVE_DEPTH = spf_pkg::ACTIVE_DEPTH_DEF,
	parameter int COORD_WIDTH  = spf_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// collider_id, min_x, max_x, min_y, max_y, min_z, max_z
	input  logic [spf_pkg::S_TDATA_W-1:0] s_tdata,
	// first
	input  logic [spf_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// new_id, other_id
	output logic [spf_pkg::M_TDATA_W-1:0] m_tdata,
	// pair_valid, overflow
	output logic [spf_pkg::M_TUSER_W-1:0] m_tuser,
	output logic                          m_tlast
);
	import spf_pkg::*;

	cmd_t    cmd;
	status_t status;

	spf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	spf_datapath #(
		.ACTIVE_DEPTH (ACTIVE_DEPTH),
		.COORD_WIDTH  (COORD_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("accepted a second item while busy");

	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> m_tlast)
		else $error("no-pair marker not flagged last");

	a_no_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!cmd.scan_rd && !cmd.emit_load && !cmd.commit))
		else $error("datapath command while idle");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> (!m_tvalid || m_tready))
		else $error("output register overwritten");

endmodule

[sim/tb_sweep_prune_pair_finder_unit.sv]
// Testbench for sweep_prune_pair_finder_unit: sorted sweeps, noise boxes and broken sweeps,
// checked against a predictor of the active list and its pair output in a scoreboard class.
// Depends on spf_pkg and the RTL of sweep_prune_pair_finder_unit.
module tb_sweep_prune_pair_finder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH = spf_pkg::ACTIVE_DEPTH_DEF;
	localparam int PAIR_LIMIT = spf_pkg::MAX_RESULTS;

	typedef logic signed [15:0] coord_t;
	typedef logic [15:0] ident_t;

	typedef struct {
		bit     first;
		ident_t ident;
		coord_t lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
	} box_t;

	typedef struct packed {
		logic   pair_valid;
		ident_t new_id;
		ident_t other_id;
		logic   overflow;
		logic   last;
	} pair_res_t;

	class pair_scoreboard;
		box_t        sweep_list[LIST_DEPTH];
		int unsigned live_count;
		pair_res_t   pending_q[$];
		int          errors;

		function new();
			live_count = 0;
			errors = 0;
		endfunction

		function bit axis_overlap(coord_t alo, coord_t ahi, coord_t blo, coord_t bhi);
			if (alo < blo)
				return ahi > blo;
			return alo < bhi;
		endfunction

		function void note_box(box_t b);
			box_t      kept_q[$];
			ident_t    hit_q[$];
			bit        ovf;
			pair_res_t r;
			if (b.first)
				live_count = 0;
			for (int i = 0; i < live_count; i++) begin
				if (!(b.lo_x < sweep_list[i].hi_x))
					continue;
				kept_q.insert(kept_q.size(), sweep_list[i]);
				if (axis_overlap(b.lo_y, b.hi_y, sweep_list[i].lo_y, sweep_list[i].hi_y) &&
				    axis_overlap(b.lo_z, b.hi_z, sweep_list[i].lo_z, sweep_list[i].hi_z) &&
				    hit_q.size() < PAIR_LIMIT)
					hit_q.insert(hit_q.size(), sweep_list[i].ident);
			end
			ovf = (kept_q.size() >= LIST_DEPTH);
			if (ovf) begin
				for (int i = 0; i < kept_q.size(); i++)
					sweep_list[i] = kept_q[i];
				live_count = kept_q.size();
			end else begin
				sweep_list[0] = b;
				for (int i = 0; i < kept_q.size(); i++)
					sweep_list[i + 1] = kept_q[i];
				live_count = kept_q.size() + 1;
			end
			if (hit_q.size() == 0) begin
				r = {1'b0, b.ident, 16'h0000, ovf, 1'b1};
				pending_q.insert(pending_q.size(), r);
			end else begin
				for (int k = 0; k < hit_q.size(); k++) begin
					r = {1'b1, b.ident, hit_q[k], ovf, (k == hit_q.size() - 1)};
					pending_q.insert(pending_q.size(), r);
				end
			end
		endfunction

		function void check_result(pair_res_t act);
			pair_res_t exp;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result pv=%0b new=%h other=%h ovf=%0b last=%0b",
					$time, act.pair_valid, act.new_id, act.other_id, act.overflow, act.last);
				return;
			end
			exp = pending_q.pop_front();
			if (exp.pair_valid !== act.pair_valid || exp.new_id !== act.new_id ||
			    exp.other_id !== act.other_id || exp.overflow !== act.overflow ||
			    exp.last !== act.last) begin
				errors++;
				$display("%0t: mismatch expected pv=%0b new=%h other=%h ovf=%0b last=%0b",
					$time, exp.pair_valid, exp.new_id, exp.other_id, exp.overflow, exp.last);
				$display("%0t: mismatch actual   pv=%0b new=%h other=%h ovf=%0b last=%0b",
					$time, act.pair_valid, act.new_id, act.other_id, act.overflow, act.last);
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [spf_pkg::S_TDATA_W-1:0] s_tdata;
	logic [spf_pkg::S_TUSER_W-1:0] s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [spf_pkg::M_TDATA_W-1:0] m_tdata;
	logic [spf_pkg::M_TUSER_W-1:0] m_tuser;
	logic                          m_tlast;

	pair_scoreboard sb = new();
	int             boxes_in = 0;

	sweep_prune_pair_finder_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic coord_t clamp16(int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return coord_t'(v);
	endfunction

	function automatic box_t mk_box(bit first, int id, int lx, int hx, int ly, int hy,
		int lz, int hz);
		box_t b;
		b.first = first;
		b.ident = ident_t'(id);
		b.lo_x = coord_t'(lx);
		b.hi_x = coord_t'(hx);
		b.lo_y = coord_t'(ly);
		b.hi_y = coord_t'(hy);
		b.lo_z = coord_t'(lz);
		b.hi_z = coord_t'(hz);
		return b;
	endfunction

	task automatic send_box(input box_t b);
		s_tvalid <= 1'b1;
		s_tdata  <= {b.hi_z, b.lo_z, b.hi_y, b.lo_y, b.hi_x, b.lo_x, b.ident};
		s_tuser  <= b.first;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic idle_cycles(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			sb.note_box(mk_box(s_tuser[0], s_tdata[15:0],
				coord_t'(s_tdata[31:16]), coord_t'(s_tdata[47:32]),
				coord_t'(s_tdata[63:48]), coord_t'(s_tdata[79:64]),
				coord_t'(s_tdata[95:80]), coord_t'(s_tdata[111:96])));
			boxes_in++;
		end
		if (arst_n && m_tvalid && m_tready)
			sb.check_result({m_tuser[0], m_tdata[15:0], m_tdata[31:16], m_tuser[1], m_tlast});
	end

	initial begin : receiver
		int cyc;
		int hold;
		bit held_long;
		cyc = 0;
		hold = 0;
		held_long = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (!held_long && boxes_in >= 120) begin
				held_long = 1'b1;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				case ((cyc / 200) % 4)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					2: m_tready <= ((cyc % 5) != 0);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		box_t stim_q[$];
		box_t b;
		box_t prev;
		int   sweep_left;
		int   cur_x;
		int   lx;
		int   ly;
		int   lz;
		int   base_y;
		int   base_z;
		int   kind;
		int   burst;
		bit   wide;
		bit   starting;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		arst_n   = 1'b0;

		// full-range boxes: pairs with all, then list full and overflow with sixteen pairs
		stim_q.insert(stim_q.size(),
			mk_box(1, 0, -32768, 32767, -32768, 32767, -32768, 32767));
		for (int k = 1; k <= 17; k++)
			stim_q.insert(stim_q.size(), mk_box(0, 16'hffff - k + 1, -32768 + k * 10, 32767,
				-32768, 32767, -32768, 32767));
		// clear while full, touching edges, inverted box, x pruning, top extremes
		stim_q.insert(stim_q.size(), mk_box(1, 16'h1234, 0, 100, 0, 100, 0, 100));
		stim_q.insert(stim_q.size(), mk_box(0, 16'h1235, 10, 200, 100, 200, 0, 100));
		stim_q.insert(stim_q.size(), mk_box(0, 16'h1236, 20, 5, 50, 10, 50, 10));
		stim_q.insert(stim_q.size(), mk_box(0, 16'h1237, 200, 300, 0, 100, 0, 100));
		stim_q.insert(stim_q.size(),
			mk_box(0, 16'h0000, 32767, 32767, 32767, 32767, -32768, -32768));

		sweep_left = 0;
		cur_x = 0;
		wide = 1'b0;
		base_y = 0;
		base_z = 0;
		prev = stim_q[stim_q.size() - 1];
		for (int n = 0; n < 380; n++) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				b = mk_box($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom);
			end else begin
				starting = (sweep_left == 0);
				if (starting) begin
					sweep_left = $urandom_range(1, 40);
					cur_x = int'($urandom_range(0, 52767)) - 32768;
					wide = ($urandom_range(0, 3) == 0);
					base_y = int'($urandom_range(0, 60000)) - 30000;
					base_z = int'($urandom_range(0, 60000)) - 30000;
				end
				sweep_left--;
				cur_x += wide ? int'($urandom_range(0, 40)) : int'($urandom_range(0, 600));
				lx = (cur_x > 32767) ? 32767 : cur_x;
				ly = base_y + int'($urandom_range(0, 1600)) - 800;
				lz = base_z + int'($urandom_range(0, 1600)) - 800;
				b = mk_box(starting, $urandom, lx,
					clamp16(lx + (wide ? int'($urandom_range(4000, 40000)) :
						int'($urandom_range(0, 1500)))),
					clamp16(ly), clamp16(ly + int'($urandom_range(0, 900))),
					clamp16(lz), clamp16(lz + int'($urandom_range(0, 900))));
				if (kind == 1) begin
					case ($urandom_range(0, 3))
						0: begin
							b.lo_y = b.hi_y;
							b.hi_y = clamp16(ly);
						end
						1: b.lo_y = prev.hi_y;
						2: b.hi_z = prev.lo_z;
						default: b.lo_x = clamp16(int'(prev.lo_x) - int'($urandom_range(1, 500)));
					endcase
				end
			end
			prev = b;
			stim_q.insert(stim_q.size(), b);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		while (stim_q.size() > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && stim_q.size() > 0) begin
				send_box(stim_q.pop_front());
				burst--;
			end
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 30));
		end
		s_tvalid <= 1'b0;

		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (sb.errors == 0) begin
			$display("sweep_prune_pair_finder_unit regression: pass");
		end else begin
			$display("sweep_prune_pair_finder_unit regression: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#10ms;
		$display("sweep_prune_pair_finder_unit regression: fail");
		$finish;
	end

endmodule

[sim.f]
rtl/spf_pkg.sv
rtl/spf_ctrl.sv
rtl/spf_datapath.sv
rtl/sweep_prune_pair_finder_unit.sv
sim/tb_sweep_prune_pair_finder_unit.sv
